// ----- rtl/config_text_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// config_text_tokenizer assertion macros
// Shared macros for the concurrent checks on the tokenizer ports.
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define CTT_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define CTT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/ctt_pkg.sv -----
// ----------------------------------------------------------------------------
// ctt_pkg
// Types, byte codes and keyword tables shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package ctt_pkg;

	// Token kinds as they appear on the output.
	typedef enum logic [3:0] {
		TOK_END        = 4'd0,
		TOK_OPEN_BRACE = 4'd1,
		TOK_CLOSE_BRACE = 4'd2,
		TOK_SEMICOLON  = 4'd3,
		TOK_DOT        = 4'd4,
		TOK_PROJECT    = 4'd5,
		TOK_EXECUTABLE = 4'd6,
		TOK_IDENT      = 4'd7,
		TOK_ERROR      = 4'd8
	} token_kind_t;

	// Scanner modes.
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_COMMENT = 2'd2
	} scan_mode_t;

	// One token without its text.
	typedef struct packed {
		token_kind_t kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// All tokens caused by one byte; pair marks that tok1 follows tok0.
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   pair;
	} token_group_t;

	// Byte codes.
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	// Keyword lengths and saturation limit for word lengths.
	localparam logic [15:0] KW_PROJECT_LEN    = 16'd7;
	localparam logic [15:0] KW_EXECUTABLE_LEN = 16'd10;
	localparam logic [15:0] LEN_MAX           = 16'hFFFF;

	// Queue between the scanner and the output stage.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	function automatic logic is_letter(input logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_word_byte(input logic [7:0] b);
		return is_letter(b) || (b inside {[8'h30:8'h39]});
	endfunction

	// Characters of the keyword "project".
	function automatic logic [7:0] kw_project_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h70;
			3'd1: c = 8'h72;
			3'd2: c = 8'h6F;
			3'd3: c = 8'h6A;
			3'd4: c = 8'h65;
			3'd5: c = 8'h63;
			3'd6: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of the keyword "executable".
	function automatic logic [7:0] kw_executable_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h65;
			4'd1: c = 8'h78;
			4'd2: c = 8'h65;
			4'd3: c = 8'h63;
			4'd4: c = 8'h75;
			4'd5: c = 8'h74;
			4'd6: c = 8'h61;
			4'd7: c = 8'h62;
			4'd8: c = 8'h6C;
			4'd9: c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/config_text_tokenizer.sv -----
// A token passes from the scanner through the queue to the output register.
// Throughput: one text byte and one token per cycle while out_stall is low;
// a byte that ends a word and is itself a token gives two tokens, which the
// four-group queue absorbs; input stalls only while that queue is full.
// Reset: arst_n clears the scanner to idle with offset zero and empties the
// queue and output register; the end byte also restarts the offset at zero.
// ----------------------------------------------------------------------------
// config_text_tokenizer
// Streaming tokenizer for configuration text, one byte per item in and one
// token per item out.
// ----------------------------------------------------------------------------
module config_text_tokenizer #(
	parameter longint unsigned TEXT_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	import ctt_pkg::*;

	token_group_t push_group;
	token_group_t head_group;
	logic         push;
	logic         pop;
	logic         empty;
	logic         full;
	logic         accept;

	// The scanner takes a valid byte whenever the queue has a free slot.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	ctt_front #(
		.TEXT_BYTES(TEXT_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.text_byte(text_byte),
		.push     (push),
		.group    (push_group)
	);

	ctt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_group(push_group),
		.pop       (pop),
		.head_group(head_group),
		.empty     (empty),
		.full      (full)
	);

	ctt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_group  (head_group),
		.head_valid  (!empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.last_of_run (last_of_run)
	);

endmodule

// ----- rtl/ctt_front.sv -----
// ----------------------------------------------------------------------------
// ctt_front
// Scanner: accepts one text byte per cycle while accept is high, tracks the word
// and comment state, and forms the group of tokens that the byte causes.
// ----------------------------------------------------------------------------
module ctt_front #(
	parameter longint unsigned TEXT_BYTES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            text_byte,
	output logic                  push,
	output ctt_pkg::token_group_t group
);
	import ctt_pkg::*;

	// Offset wraps at the smaller of the text size and the 16-bit range.
	localparam longint unsigned OFS_LIMIT =
		(TEXT_BYTES > 64'd65536) ? 64'd65536 : TEXT_BYTES;
	localparam logic [16:0] OFS_LAST = 17'(OFS_LIMIT - 64'd1);

	scan_mode_t  mode_q, mode_d;
	logic [15:0] offset_q, offset_d, offset_adv;
	logic [15:0] begin_q, begin_d;
	logic [15:0] count_q, count_d;
	logic        proj_q, proj_d;
	logic        exec_q, exec_d;
	logic        muted_q, muted_d;
	logic        emit;
	logic        idle_emit;
	logic        ending;
	token_t      word_tok;
	token_t      idle_tok;
	token_t      end_tok;
	token_kind_t word_kind;

	// Next offset with wrap.
	assign offset_adv = ({1'b0, offset_q} == OFS_LAST) ? 16'd0 : offset_q + 16'd1;

	// Kind of the word held so far.
	always_comb begin
		if (proj_q && count_q == KW_PROJECT_LEN) begin
			word_kind = TOK_PROJECT;
		end else if (exec_q && count_q == KW_EXECUTABLE_LEN) begin
			word_kind = TOK_EXECUTABLE;
		end else begin
			word_kind = TOK_IDENT;
		end
	end

	assign word_tok = '{kind: word_kind, start: begin_q, length: count_q};
	assign end_tok  = '{kind: TOK_END, start: offset_q, length: 16'd0};

	// Byte classification and next state.
	always_comb begin
		mode_d    = mode_q;
		offset_d  = offset_adv;
		begin_d   = begin_q;
		count_d   = count_q;
		proj_d    = proj_q;
		exec_d    = exec_q;
		muted_d   = muted_q;
		emit      = 1'b0;
		idle_emit = 1'b0;
		ending    = 1'b0;
		idle_tok  = '{kind: TOK_ERROR, start: offset_q, length: 16'd1};
		group     = '{tok0: end_tok, tok1: end_tok, pair: 1'b0};

		if (text_byte == CH_NUL) begin
			// End of text: flush a pending word, then the end token, then reset.
			emit = 1'b1;
			if (mode_q == MODE_WORD && !muted_q) begin
				group.tok0 = word_tok;
				group.pair = 1'b1;
			end
			mode_d   = MODE_IDLE;
			offset_d = 16'd0;
			begin_d  = 16'd0;
			count_d  = 16'd0;
			proj_d   = 1'b0;
			exec_d   = 1'b0;
			muted_d  = 1'b0;
		end else if (muted_q) begin
			// Output stays muted until the end byte.
		end else if (mode_q == MODE_COMMENT) begin
			if (text_byte == CH_LF) begin
				mode_d = MODE_IDLE;
			end
		end else if (mode_q == MODE_WORD && is_word_byte(text_byte)) begin
			// Word continues: narrow the keyword candidates.
			proj_d = (proj_q && count_q < KW_PROJECT_LEN) ?
				(text_byte == kw_project_char(count_q[2:0])) : 1'b0;
			exec_d = (exec_q && count_q < KW_EXECUTABLE_LEN) ?
				(text_byte == kw_executable_char(count_q[3:0])) : 1'b0;
			count_d = (count_q == LEN_MAX) ? count_q : count_q + 16'd1;
		end else begin
			// Between tokens, possibly right after a word that ends here.
			ending = (mode_q == MODE_WORD);
			mode_d = MODE_IDLE;
			case (text_byte)
				CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
				end
				CH_HASH: begin
					mode_d = MODE_COMMENT;
				end
				CH_LBRACE: begin
					idle_emit     = 1'b1;
					idle_tok.kind = TOK_OPEN_BRACE;
				end
				CH_RBRACE: begin
					idle_emit     = 1'b1;
					idle_tok.kind = TOK_CLOSE_BRACE;
				end
				CH_SEMICOLON: begin
					idle_emit     = 1'b1;
					idle_tok.kind = TOK_SEMICOLON;
				end
				CH_DOT: begin
					idle_emit     = 1'b1;
					idle_tok.kind = TOK_DOT;
				end
				default: begin
					if (is_letter(text_byte)) begin
						mode_d  = MODE_WORD;
						begin_d = offset_q;
						count_d = 16'd1;
						proj_d  = (text_byte == kw_project_char(3'd0));
						exec_d  = (text_byte == kw_executable_char(4'd0));
					end else begin
						idle_emit = 1'b1;
						muted_d   = 1'b1;
					end
				end
			endcase

			emit = ending || idle_emit;
			if (ending) begin
				group.tok0 = word_tok;
				group.tok1 = idle_tok;
				group.pair = idle_emit;
			end else begin
				group.tok0 = idle_tok;
			end
		end
	end

	assign push = accept && emit;

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			offset_q <= 16'd0;
			begin_q  <= 16'd0;
			count_q  <= 16'd0;
			proj_q   <= 1'b0;
			exec_q   <= 1'b0;
			muted_q  <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			offset_q <= offset_d;
			begin_q  <= begin_d;
			count_q  <= count_d;
			proj_q   <= proj_d;
			exec_q   <= exec_d;
			muted_q  <= muted_d;
		end
	end

endmodule

// ----- rtl/ctt_fifo.sv -----
// ----------------------------------------------------------------------------
// ctt_fifo
// Short queue of token groups between the scanner and the output stage.
// ----------------------------------------------------------------------------
module ctt_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ctt_pkg::token_group_t push_group,
	input  logic                  pop,
	output ctt_pkg::token_group_t head_group,
	output logic                  empty,
	output logic                  full
);
	import ctt_pkg::*;

	token_group_t         entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign empty      = (count_q == '0);
	assign full       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head_group = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_group;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ctt_back.sv -----
// ----------------------------------------------------------------------------
// ctt_back
// Output stage: splits each token group into single items and holds the
// current item in an output register until it is taken.
// ----------------------------------------------------------------------------
module ctt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctt_pkg::token_group_t head_group,
	input  logic                  head_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            token_kind,
	output logic [15:0]           token_start,
	output logic [15:0]           token_length,
	output logic                  last_of_run
);
	import ctt_pkg::*;

	logic   out_valid_q;
	token_t out_tok_q;
	logic   out_last_q;
	logic   second_valid_q;
	token_t second_tok_q;
	logic   load;

	// The output register can take a new item when empty or being drained.
	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !second_valid_q && head_valid;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (load) begin
			if (second_valid_q) begin
				out_valid_q    <= 1'b1;
				second_valid_q <= 1'b0;
			end else begin
				out_valid_q    <= head_valid;
				second_valid_q <= head_valid && head_group.pair;
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (second_valid_q) begin
				out_tok_q  <= second_tok_q;
				out_last_q <= 1'b1;
			end else begin
				out_tok_q    <= head_group.tok0;
				out_last_q   <= !head_group.pair;
				second_tok_q <= head_group.tok1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = out_tok_q.kind;
	assign token_start  = out_tok_q.start;
	assign token_length = out_tok_q.length;
	assign last_of_run  = out_last_q;

endmodule

// ----- rtl/ctt_checker.sv -----
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks on the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
`include "config_text_tokenizer_assert.svh"

module ctt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic        last_of_run
);
	import ctt_pkg::*;

	// A held item keeps its contents.
	`CTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(last_of_run), "output item changed while stalled")

	// The end token is empty and always closes its run.
	`CTT_ASSERT_SAME(a_end_shape, out_valid && token_kind == TOK_END, token_length == 16'd0 && last_of_run, "malformed end token")

	// Single-byte tokens are one byte long and close their run.
	`CTT_ASSERT_SAME(a_single_shape, out_valid && (token_kind == TOK_OPEN_BRACE || token_kind == TOK_CLOSE_BRACE || token_kind == TOK_SEMICOLON || token_kind == TOK_DOT || token_kind == TOK_ERROR), token_length == 16'd1 && last_of_run, "malformed single-byte token")

	// Keywords have their exact lengths.
	`CTT_ASSERT_SAME(a_kw_length, out_valid && (token_kind == TOK_PROJECT || token_kind == TOK_EXECUTABLE), (token_kind == TOK_PROJECT && token_length == KW_PROJECT_LEN) || (token_kind == TOK_EXECUTABLE && token_length == KW_EXECUTABLE_LEN), "keyword token with wrong length")

	// No kind code outside the defined set.
	`CTT_ASSERT_SAME(a_kind_range, out_valid, token_kind <= 4'd8, "undefined token kind")

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);
